// File: hdl/mtw_pkg.sv
// ----------------------------------------------------------------------------
// mtw_pkg: shared types and constants of the message timer wheel
// Holds the slot count, action and status codes and the command beat that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mtw_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Action codes on the command port
  localparam logic [2:0] ACT_TICK         = 3'd0;
  localparam logic [2:0] ACT_START        = 3'd1;
  localparam logic [2:0] ACT_CANCEL_FIRST = 3'd2;
  localparam logic [2:0] ACT_CANCEL_ALL   = 3'd3;
  localparam logic [2:0] ACT_FLUSH        = 3'd4;
  localparam logic [2:0] ACT_QUERY_REM    = 3'd5;
  localparam logic [2:0] ACT_QUERY_PRES   = 3'd6;

  // Status codes of a completion
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_STOPPED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Result kinds
  localparam logic KIND_DONE    = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  // Classified operation
  typedef enum logic [3:0] {
    OP_TICK,
    OP_START_ERR,
    OP_START_NOW,
    OP_START,
    OP_CANCEL_FIRST,
    OP_CANCEL_ALL,
    OP_FLUSH,
    OP_QUERY_REM,
    OP_QUERY_PRES,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  pid;
    logic [15:0] mid;
    logic [31:0] arg;
    logic [31:0] delay;
    logic [31:0] period;
  } cmd_t;

endpackage

`default_nettype wire

// File: hdl/message_timer_wheel.sv
// ----------------------------------------------------------------------------
// message_timer_wheel: pool of message timers with in-order delivery
// Keeps 16 timers; ticks deliver due timers, commands arm, cancel and query.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken at a clock edge with start high and busy low.
//   A two-entry queue sits ahead of the executor, so busy rises only when
//   two commands wait behind the one in progress.
//   Each result shows for one cycle with result_valid high; last marks the
//   final result of a command. The receiver cannot stall results.
// Timing:
//   Start to a stopped target and unused codes: completion in the cycle after dequeue.
//   Immediate start: delivery then completion in consecutive cycles.
//   Other commands: one scan of the slots, then a finish step.
//   Tick: one scan per due timer plus a final scan, each followed by a finish
//   step; the timer store is scanned a single slot per cycle.
// Reset:
//   rst (synchronous) empties the queue, frees every timer and clears the
//   tick and rank counters.
// ----------------------------------------------------------------------------
`default_nettype none

module message_timer_wheel import mtw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  process_id,
  input  wire logic        target_running,
  input  wire logic [15:0] message_id,
  input  wire logic [31:0] arg_handle,
  input  wire logic [31:0] delay,
  input  wire logic [31:0] period,
  output logic             result_valid,
  output logic             kind,
  output logic [7:0]       out_process_id,
  output logic [15:0]      out_message_id,
  output logic [31:0]      out_arg_handle,
  output logic [1:0]       status,
  output logic [31:0]      remaining,
  output logic             found,
  output logic             last
);

  cmd_t q_data;
  logic q_valid;
  logic q_pop;

  // Take in and classify commands
  mtw_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .process_id     (process_id),
    .target_running (target_running),
    .message_id     (message_id),
    .arg_handle     (arg_handle),
    .delay          (delay),
    .period         (period),
    .q_data         (q_data),
    .q_valid        (q_valid),
    .q_pop          (q_pop)
  );

  // Execute against the timer pool
  mtw_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_data         (q_data),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .result_valid   (result_valid),
    .kind           (kind),
    .out_process_id (out_process_id),
    .out_message_id (out_message_id),
    .out_arg_handle (out_arg_handle),
    .status         (status),
    .remaining      (remaining),
    .found          (found),
    .last           (last)
  );

endmodule

`default_nettype wire

// File: hdl/mtw_front.sv
// ----------------------------------------------------------------------------
// mtw_front: command intake and classification
// Accepts a command beat, classifies it and holds it in a two-entry queue
// until the back end takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mtw_front import mtw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  process_id,
  input  wire logic        target_running,
  input  wire logic [15:0] message_id,
  input  wire logic [31:0] arg_handle,
  input  wire logic [31:0] delay,
  input  wire logic [31:0] period,
  output cmd_t             q_data,
  output logic             q_valid,
  input  wire logic        q_pop
);

  cmd_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       push;
  logic       pop;

  // Classify the incoming beat
  always_comb begin
    cls.pid    = process_id;
    cls.mid    = message_id;
    cls.arg    = arg_handle;
    cls.delay  = delay;
    cls.period = period;
    unique case (action)
      ACT_TICK:         cls.op = OP_TICK;
      ACT_START: begin
        if (!target_running)      cls.op = OP_START_ERR;
        else if (delay == 32'd0)  cls.op = OP_START_NOW;
        else                      cls.op = OP_START;
      end
      ACT_CANCEL_FIRST: cls.op = OP_CANCEL_FIRST;
      ACT_CANCEL_ALL:   cls.op = OP_CANCEL_ALL;
      ACT_FLUSH:        cls.op = OP_FLUSH;
      ACT_QUERY_REM:    cls.op = OP_QUERY_REM;
      ACT_QUERY_PRES:   cls.op = OP_QUERY_PRES;
      default:          cls.op = OP_NOP;
    endcase
  end

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign pop     = q_pop && q_valid;
  assign q_data  = fifo[rd_ptr];

  // Hold queued beats
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// File: hdl/mtw_back.sv
// ----------------------------------------------------------------------------
// mtw_back: timer pool and command execution
// Holds the timer slots and scans them one slot per cycle to arm, match,
// cancel, query and deliver due timers in arming order.
// ----------------------------------------------------------------------------
`default_nettype none

module mtw_back import mtw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        q_data,
  input  wire logic        q_valid,
  output logic             q_pop,
  output logic             result_valid,
  output logic             kind,
  output logic [7:0]       out_process_id,
  output logic [15:0]      out_message_id,
  output logic [31:0]      out_arg_handle,
  output logic [1:0]       status,
  output logic [31:0]      remaining,
  output logic             found,
  output logic             last
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH, S_NOW_DONE} state_t;

  state_t                   state;
  cmd_t                     cmd;
  logic [SLOT_W-1:0]        idx;
  logic                     hit;
  logic                     any;
  logic [SLOT_W-1:0]        best_idx;
  logic [31:0]              best_age;
  logic [7:0]               best_pid;
  logic [15:0]              best_mid;
  logic [31:0]              best_arg;
  logic [31:0]              best_period;
  logic [31:0]              best_due;
  logic                     pend_valid;
  logic [7:0]               pend_pid;
  logic [15:0]              pend_mid;
  logic [31:0]              pend_arg;
  logic [CNT_W-1:0]         dcount;
  logic [31:0]              tick_count;
  logic [31:0]              rank_counter;
  logic [TIMER_SLOTS-1:0]   slot_valid;
  logic [7:0]               slot_process    [TIMER_SLOTS];
  logic [15:0]              slot_message    [TIMER_SLOTS];
  logic [31:0]              slot_arg        [TIMER_SLOTS];
  logic [31:0]              slot_period     [TIMER_SLOTS];
  logic [31:0]              slot_due        [TIMER_SLOTS];
  logic [31:0]              slot_fire_rank  [TIMER_SLOTS];
  logic [31:0]              slot_start_rank [TIMER_SLOTS];

  logic        sv;
  logic        pmatch;
  logic        mmatch;
  logic [31:0] rank_sel;
  logic [31:0] age;
  logic        cand;
  logic        take;
  logic        scan_end;

  assign q_pop = (state == S_IDLE);

  // Evaluate the slot under the scan pointer
  always_comb begin
    sv       = slot_valid[idx];
    pmatch   = (slot_process[idx] == cmd.pid);
    mmatch   = (slot_message[idx] == cmd.mid);
    rank_sel = (cmd.op == OP_TICK) ? slot_fire_rank[idx] : slot_start_rank[idx];
    age      = rank_counter - rank_sel;
    unique case (cmd.op)
      OP_TICK:         cand = sv && (slot_due[idx] == tick_count);
      OP_START:        cand = !sv;
      OP_CANCEL_FIRST,
      OP_CANCEL_ALL,
      OP_QUERY_REM,
      OP_QUERY_PRES:   cand = sv && pmatch && mmatch;
      OP_FLUSH:        cand = sv && pmatch;
      default:         cand = 1'b0;
    endcase
    take     = cand && (!hit || (cmd.op != OP_START && age > best_age));
    scan_end = (idx == SLOT_W'(TIMER_SLOTS - 1));
  end

  // Sequence commands, hold the pool and drive results
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      tick_count   <= 32'd0;
      rank_counter <= 32'd0;
      slot_valid   <= '0;
      pend_valid   <= 1'b0;
      hit          <= 1'b0;
      any          <= 1'b0;
      dcount       <= '0;
      idx          <= '0;
    end else begin
      result_valid   <= 1'b0;
      kind           <= KIND_DONE;
      out_process_id <= 8'd0;
      out_message_id <= 16'd0;
      out_arg_handle <= 32'd0;
      status         <= ST_OK;
      remaining      <= 32'd0;
      found          <= 1'b0;
      last           <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd        <= q_data;
            idx        <= '0;
            hit        <= 1'b0;
            any        <= 1'b0;
            dcount     <= '0;
            pend_valid <= 1'b0;
            unique case (q_data.op)
              OP_TICK: begin
                tick_count <= tick_count + 32'd1;
                state      <= S_SCAN;
              end
              OP_START_ERR: begin
                result_valid <= 1'b1;
                status       <= ST_STOPPED;
              end
              OP_START_NOW: begin
                result_valid   <= 1'b1;
                kind           <= KIND_DELIVER;
                out_process_id <= q_data.pid;
                out_message_id <= q_data.mid;
                out_arg_handle <= q_data.arg;
                last           <= 1'b0;
                state          <= S_NOW_DONE;
              end
              OP_NOP: begin
                result_valid <= 1'b1;
              end
              default: state <= S_SCAN;
            endcase
          end
        end
        S_SCAN: begin
          if (take) begin
            hit         <= 1'b1;
            best_idx    <= idx;
            best_age    <= age;
            best_pid    <= slot_process[idx];
            best_mid    <= slot_message[idx];
            best_arg    <= slot_arg[idx];
            best_period <= slot_period[idx];
            best_due    <= slot_due[idx];
          end
          // drop every match of a bulk cancel as it is seen
          if (cand && (cmd.op == OP_CANCEL_ALL || cmd.op == OP_FLUSH)) begin
            slot_valid[idx] <= 1'b0;
            any             <= 1'b1;
          end
          if (scan_end) state <= S_FINISH;
          else          idx   <= idx + SLOT_W'(1);
        end
        S_FINISH: begin
          state <= S_IDLE;
          unique case (cmd.op)
            OP_TICK: begin
              if (hit) begin
                if (dcount < CNT_W'(MAX_RESULTS)) begin
                  // emit the held delivery, keep the new one back
                  if (pend_valid) begin
                    result_valid   <= 1'b1;
                    kind           <= KIND_DELIVER;
                    out_process_id <= pend_pid;
                    out_message_id <= pend_mid;
                    out_arg_handle <= pend_arg;
                    last           <= 1'b0;
                  end
                  pend_valid <= 1'b1;
                  pend_pid   <= best_pid;
                  pend_mid   <= best_mid;
                  pend_arg   <= best_arg;
                  dcount     <= dcount + CNT_W'(1);
                end
                if (best_period != 32'd0) begin
                  slot_due[best_idx]       <= tick_count + best_period;
                  slot_fire_rank[best_idx] <= rank_counter;
                  rank_counter             <= rank_counter + 32'd1;
                end else begin
                  slot_valid[best_idx] <= 1'b0;
                end
                idx   <= '0;
                hit   <= 1'b0;
                state <= S_SCAN;
              end else begin
                result_valid <= 1'b1;
                if (pend_valid) begin
                  kind           <= KIND_DELIVER;
                  out_process_id <= pend_pid;
                  out_message_id <= pend_mid;
                  out_arg_handle <= pend_arg;
                  pend_valid     <= 1'b0;
                end
              end
            end
            OP_START: begin
              result_valid <= 1'b1;
              if (hit) begin
                slot_valid[best_idx]      <= 1'b1;
                slot_process[best_idx]    <= cmd.pid;
                slot_message[best_idx]    <= cmd.mid;
                slot_arg[best_idx]        <= cmd.arg;
                slot_period[best_idx]     <= cmd.period;
                slot_due[best_idx]        <= tick_count + cmd.delay;
                slot_fire_rank[best_idx]  <= rank_counter;
                slot_start_rank[best_idx] <= rank_counter;
                rank_counter              <= rank_counter + 32'd1;
              end else begin
                status <= ST_FULL;
              end
            end
            OP_CANCEL_FIRST: begin
              result_valid <= 1'b1;
              found        <= hit;
              if (hit) slot_valid[best_idx] <= 1'b0;
            end
            OP_CANCEL_ALL, OP_FLUSH: begin
              result_valid <= 1'b1;
              found        <= any;
            end
            OP_QUERY_REM: begin
              result_valid <= 1'b1;
              found        <= hit;
              if (hit) remaining <= best_due - tick_count;
            end
            default: begin
              result_valid <= 1'b1;
              found        <= hit;
            end
          endcase
        end
        S_NOW_DONE: begin
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A delivery never carries completion status
  a_deliver_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind |-> status == ST_OK && !found && remaining == 32'd0)
    else $error("delivery with completion fields");

  // An immediate start closes with a completion right after its delivery
  a_now_pair: assert property (@(posedge clk) disable iff (rst)
    state == S_NOW_DONE |-> result_valid && kind && !last)
    else $error("immediate start without delivery");

  // An arming start occupies the chosen slot
  a_arm_slot: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && cmd.op == OP_START && hit |=> slot_valid[$past(best_idx)])
    else $error("armed slot not valid");

  // Commands are taken only while idle
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |=> $stable(cmd))
    else $error("command changed mid-execution");

endmodule

`default_nettype wire
